/* rtl/lbr_pkg.sv */
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared widths, register indexes and the setup sequencer states of the
// letterbox resize address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lbr_pkg;

  localparam int COORD_W    = 12;  // out_x, out_y, src_col, src_row
  localparam int INDEX_W    = 24;  // src_index
  localparam int FILL_W     = 8;   // fill_level, pad_value
  localparam int DIM_REG_W  = 13;  // src_width, src_height, out_side
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SIDE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_LEVEL  = 3'd4;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 13'd640;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OFFS = 5'b10000
  } setup_state_t;

endpackage

`default_nettype wire

/* rtl/lbr_if.sv */
// ----------------------------------------------------------------------------
// lbr_in_if / lbr_out_if
// Valid/ready channels: output pixel coordinates in, source addresses out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbr_in_if import lbr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface lbr_out_if import lbr_pkg::*;;
  logic               valid;
  logic               ready;
  logic               in_image;
  logic [COORD_W-1:0] src_col;
  logic [COORD_W-1:0] src_row;
  logic [INDEX_W-1:0] src_index;
  logic [FILL_W-1:0]  pad_value;

  modport source (output valid, output in_image, output src_col, output src_row,
                  output src_index, output pad_value, input ready);
  modport sink   (input valid, input in_image, input src_col, input src_row,
                  input src_index, input pad_value, output ready);
endinterface

`default_nettype wire

/* rtl/letterbox_resize_address_gen.sv */
// ----------------------------------------------------------------------------
// letterbox_resize_address_gen
// Maps each output pixel of a square letterboxed frame to its nearest-
// neighbor source pixel, or to padding with the fill level.
// ----------------------------------------------------------------------------
// Pipeline: region test, multiply, one-bit-per-stage divider of width
//   W = $clog2(MAX_DIM+1), clamp, row offset and the output register.
// Throughput: one word per cycle outside setup; stalls propagate through a
//   global enable. Reset and every config write start the geometry setup
//   (load, multiply, divide, offsets), during which pix_in.ready is low.
// Reset is synchronous; config registers return to 640/640/640, top left, 0.
// ----------------------------------------------------------------------------
`default_nettype none

module letterbox_resize_address_gen import lbr_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  lbr_in_if.sink                pix_in,
  lbr_out_if.source             pix_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W  = $clog2(MAX_DIM + 1);           // internal dimension width
  localparam int PW = 2 * W;                          // coordinate product width
  localparam int CW = (W + 1 > COORD_W) ? W + 1 : COORD_W;  // compare width
  localparam int OW = (W > COORD_W) ? W : COORD_W;
  localparam int XW = (PW > INDEX_W) ? PW : INDEX_W;

  // Geometry, stable while words are in flight (config only when idle).
  logic              busy;
  logic [W-1:0]      iw, ih, side, nw, nh, dx, dy;
  logic [W:0]        x_end, y_end;
  logic [FILL_W-1:0] fill;

  lbr_setup #(
    .MAX_DIM (MAX_DIM),
    .W       (W)
  ) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .iw        (iw),
    .ih        (ih),
    .side      (side),
    .nw        (nw),
    .nh        (nh),
    .dx        (dx),
    .dy        (dy),
    .x_end     (x_end),
    .y_end     (y_end),
    .fill      (fill)
  );

  // Whole pipeline moves together; the output register is the last stage, so a
  // new word enters when the output is empty or being taken and busy is low.
  logic en;
  logic out_v;

  assign en           = !out_v || pix_out.ready;
  assign pix_in.ready = en && !busy;

  // Stage 1: region test and local offset inside the scaled image.
  logic [CW-1:0] xc, yc;
  logic [CW-1:0] lx_full, ly_full;
  logic          in_region;
  logic          v1, in1;
  logic [W-1:0]  lx1, ly1;

  always_comb begin
    xc        = CW'(pix_in.out_x);
    yc        = CW'(pix_in.out_y);
    in_region = (nw != '0) && (nh != '0) &&
                (xc < CW'(side)) && (yc < CW'(side)) &&
                (xc >= CW'(dx)) && (xc < CW'(x_end)) &&
                (yc >= CW'(dy)) && (yc < CW'(y_end));
    lx_full   = xc - CW'(dx);
    ly_full   = yc - CW'(dy);
  end

  // Stage 2: local * source size, numerator of the coordinate divide.
  logic          v2, in2;
  logic [PW-1:0] px2, py2;

  // Divider stages carry valid and the in-region flag alongside.
  logic [W-1:0] v_d, in_d;
  logic [W-1:0] quo_x, quo_y;

  lbr_coord_div #(.W(W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (px2),
    .den (nw),
    .quo (quo_x)
  );

  lbr_coord_div #(.W(W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (py2),
    .den (nh),
    .quo (quo_y)
  );

  // Stage 3: clamp to the last source pixel.
  logic         v3, in3;
  logic [W-1:0] sx3, sy3;

  // Stage 4: row offset for the linear index.
  logic          v4, in4;
  logic [W-1:0]  sx4, sy4;
  logic [XW-1:0] row4;

  // Stage 5: output register.
  logic [XW-1:0] idx_sum;
  logic [OW-1:0] sx_ext, sy_ext;
  logic          in_image;
  logic [COORD_W-1:0] src_col, src_row;
  logic [INDEX_W-1:0] src_index;
  logic [FILL_W-1:0]  pad_value;

  always_comb begin
    idx_sum = row4 + XW'(sx4);
    sx_ext  = OW'(sx4);
    sy_ext  = OW'(sy4);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v_d   <= '0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= pix_in.valid && !busy;
      v2    <= v1;
      v_d   <= {v_d[W-2:0], v2};
      v3    <= v_d[W-1];
      v4    <= v3;
      out_v <= v4;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      in1  <= in_region;
      lx1  <= lx_full[W-1:0];
      ly1  <= ly_full[W-1:0];

      in2  <= in1;
      px2  <= PW'(lx1) * PW'(iw);
      py2  <= PW'(ly1) * PW'(ih);

      in_d <= {in_d[W-2:0], in2};

      in3  <= in_d[W-1];
      sx3  <= (quo_x >= iw) ? iw - 1'b1 : quo_x;
      sy3  <= (quo_y >= ih) ? ih - 1'b1 : quo_y;

      in4  <= in3;
      sx4  <= sx3;
      sy4  <= sy3;
      row4 <= XW'(sy3) * XW'(iw);

      in_image  <= in4;
      src_col   <= in4 ? sx_ext[COORD_W-1:0] : '0;
      src_row   <= in4 ? sy_ext[COORD_W-1:0] : '0;
      src_index <= in4 ? idx_sum[INDEX_W-1:0] : '0;
      pad_value <= in4 ? '0 : fill;
    end
  end

  assign pix_out.valid     = out_v;
  assign pix_out.in_image  = in_image;
  assign pix_out.src_col   = src_col;
  assign pix_out.src_row   = src_row;
  assign pix_out.src_index = src_index;
  assign pix_out.pad_value = pad_value;

endmodule

`default_nettype wire

/* rtl/lbr_setup.sv */
// ----------------------------------------------------------------------------
// lbr_setup
// Configuration registers and the frame geometry sequencer: scaled size by
// a bit-serial divider, then the letterbox offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_setup import lbr_pkg::*; #(
  parameter int MAX_DIM = 4096,
  parameter int W       = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  busy,
  output logic [W-1:0]          iw,
  output logic [W-1:0]          ih,
  output logic [W-1:0]          side,
  output logic [W-1:0]          nw,
  output logic [W-1:0]          nh,
  output logic [W-1:0]          dx,
  output logic [W-1:0]          dy,
  output logic [W:0]            x_end,
  output logic [W:0]            y_end,
  output logic [FILL_W-1:0]     fill
);

  localparam int SW    = (W > DIM_REG_W) ? W : DIM_REG_W;
  localparam int PW    = 2 * W;
  localparam int CNT_W = $clog2(W);

  logic [DIM_REG_W-1:0] src_width;
  logic [DIM_REG_W-1:0] src_height;
  logic [DIM_REG_W-1:0] out_side;
  logic                 center_mode;

  setup_state_t state;
  logic [CNT_W-1:0] cnt;

  logic [W-1:0]  scale;
  logic [W-1:0]  rem [2];
  logic [W-1:0]  low [2];
  logic [W-1:0]  quo [2];

  logic [W-1:0]  max_src;
  logic [W-1:0]  scale_next;
  logic [PW-1:0] prod [2];
  logic [W:0]    trial [2];
  logic [W:0]    diff [2];
  logic          ge [2];
  logic [W-1:0]  nw_fin;
  logic [W-1:0]  nh_fin;
  logic [W-1:0]  dx_next;
  logic [W-1:0]  dy_next;

  function automatic logic [W-1:0] sat_dim(input logic [DIM_REG_W-1:0] v);
    logic [SW-1:0] e;
    logic [SW-1:0] lim;
    logic [SW-1:0] s;
    e   = SW'(v);
    lim = SW'(MAX_DIM);
    s   = (e > lim) ? lim : e;
    return s[W-1:0];
  endfunction

  always_comb begin
    max_src    = (iw > ih) ? iw : ih;
    scale_next = (side > max_src) ? side : max_src;
    prod[0]    = PW'(iw) * PW'(side);
    prod[1]    = PW'(ih) * PW'(side);
    for (int k = 0; k < 2; k++) begin
      trial[k] = {rem[k], low[k][W-1]};
      ge[k]    = trial[k] >= {1'b0, scale};
      diff[k]  = trial[k] - {1'b0, scale};
    end
    // all three sizes zero: no scale, nothing inside
    nw_fin  = (scale == '0) ? '0 : quo[0];
    nh_fin  = (scale == '0) ? '0 : quo[1];
    dx_next = center_mode ? ((side - nw_fin) >> 1) : '0;
    dy_next = center_mode ? ((side - nh_fin) >> 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      cnt         <= '0;
      src_width   <= DIM_RESET;
      src_height  <= DIM_RESET;
      out_side    <= DIM_RESET;
      center_mode <= 1'b0;
      fill        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC_WIDTH:   src_width   <= cfg_data[DIM_REG_W-1:0];
          REG_SRC_HEIGHT:  src_height  <= cfg_data[DIM_REG_W-1:0];
          REG_OUT_SIDE:    out_side    <= cfg_data[DIM_REG_W-1:0];
          REG_CENTER_MODE: center_mode <= cfg_data[0];
          REG_FILL_LEVEL:  fill        <= cfg_data[FILL_W-1:0];
          default: ;
        endcase
      end
      if (cfg_we) begin
        state <= ST_LOAD;
      end else begin
        unique case (state)
          ST_IDLE: state <= ST_IDLE;
          ST_LOAD: state <= ST_MUL;
          ST_MUL: begin
            state <= ST_DIV;
            cnt   <= '0;
          end
          ST_DIV: begin
            if (cnt == CNT_W'(W - 1)) begin
              state <= ST_OFFS;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          ST_OFFS: state <= ST_IDLE;
          default: state <= ST_LOAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        iw   <= sat_dim(src_width);
        ih   <= sat_dim(src_height);
        side <= sat_dim(out_side);
      end
      ST_MUL: begin
        scale <= scale_next;
        for (int k = 0; k < 2; k++) begin
          rem[k] <= prod[k][PW-1:W];
          low[k] <= prod[k][W-1:0];
          quo[k] <= '0;
        end
      end
      ST_DIV: begin
        for (int k = 0; k < 2; k++) begin
          rem[k] <= ge[k] ? diff[k][W-1:0] : trial[k][W-1:0];
          low[k] <= low[k] << 1;
          quo[k] <= {quo[k][W-2:0], ge[k]};
        end
      end
      ST_OFFS: begin
        nw    <= nw_fin;
        nh    <= nh_fin;
        dx    <= dx_next;
        dy    <= dy_next;
        x_end <= {1'b0, dx_next} + {1'b0, nw_fin};
        y_end <= {1'b0, dy_next} + {1'b0, nh_fin};
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/lbr_coord_div.sv */
// ----------------------------------------------------------------------------
// lbr_coord_div
// Pipelined restoring divider, one quotient bit per stage. The numerator's
// upper half must be below the divisor; the divisor holds during use.
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_coord_div #(
  parameter int W = 13
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] num,
  input  logic [W-1:0]   den,
  output logic [W-1:0]   quo
);

  logic [W-1:0] rem_q [W];
  logic [W-1:0] low_q [W];
  logic [W-1:0] quo_q [W];

  logic [W-1:0] rem_in [W];
  logic [W-1:0] low_in [W];
  logic [W-1:0] quo_in [W];
  logic [W:0]   trial  [W];
  logic [W:0]   diff   [W];
  logic         ge     [W];

  always_comb begin
    rem_in[0] = num[2*W-1:W];
    low_in[0] = num[W-1:0];
    quo_in[0] = '0;
    for (int i = 1; i < W; i++) begin
      rem_in[i] = rem_q[i-1];
      low_in[i] = low_q[i-1];
      quo_in[i] = quo_q[i-1];
    end
    for (int i = 0; i < W; i++) begin
      trial[i] = {rem_in[i], low_in[i][W-1]};
      ge[i]    = trial[i] >= {1'b0, den};
      diff[i]  = trial[i] - {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < W; i++) begin
        rem_q[i] <= ge[i] ? diff[i][W-1:0] : trial[i][W-1:0];
        low_q[i] <= low_in[i] << 1;
        quo_q[i] <= {quo_in[i][W-2:0], ge[i]};
      end
    end
  end

  assign quo = quo_q[W-1];

endmodule

`default_nettype wire

/* sim/letterbox_addr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letterbox_addr_checker
// Watches the pixel channels and the config port of the letterbox address
// generator. It predicts each source address word and compares it with the
// block's output.
// ----------------------------------------------------------------------------

module letterbox_addr_checker import lbr_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  lbr_in_if                     pix_in,
  lbr_out_if                    pix_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           errors,
  output int unsigned           pending
);

  typedef struct packed {
    logic               in_image;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [INDEX_W-1:0] src_index;
    logic [FILL_W-1:0]  pad_value;
  } src_addr_t;

  // shadow copy of the config registers
  logic [DIM_REG_W-1:0] width_q, height_q, side_q;
  logic                 center_q;
  logic [FILL_W-1:0]    fill_q;

  src_addr_t pending_addrs[$];
  src_addr_t want;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint unsigned clamp_dim(logic [DIM_REG_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // nearest-neighbor source address of one output pixel, or padding
  function automatic src_addr_t letterbox_map(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    longint unsigned iw, ih, side, longest, scale, nw, nh, dx, dy, sx, sy;
    src_addr_t a;
    iw      = clamp_dim(width_q);
    ih      = clamp_dim(height_q);
    side    = clamp_dim(side_q);
    longest = (iw > ih) ? iw : ih;
    scale   = (side > longest) ? side : longest;
    nw = 0;
    nh = 0;
    dx = 0;
    dy = 0;
    if (scale != 0) begin
      nw = iw * side / scale;
      nh = ih * side / scale;
    end
    if (center_q) begin
      dx = (side - nw) / 2;
      dy = (side - nh) / 2;
    end
    a = '0;
    if (nw != 0 && nh != 0 && x < side && y < side &&
        x >= dx && x < dx + nw && y >= dy && y < dy + nh) begin
      sx = (x - dx) * iw / nw;
      sy = (y - dy) * ih / nh;
      if (sx >= iw) sx = iw - 1;
      if (sy >= ih) sy = ih - 1;
      a.in_image  = 1'b1;
      a.src_col   = COORD_W'(sx);
      a.src_row   = COORD_W'(sy);
      a.src_index = INDEX_W'(sy * iw + sx);
    end else begin
      a.pad_value = fill_q;
    end
    return a;
  endfunction

  task automatic check_field(string name, logic [INDEX_W-1:0] exp_v, logic [INDEX_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      side_q   <= DIM_RESET;
      center_q <= 1'b0;
      fill_q   <= '0;
      pending_addrs.delete();
      pending  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:   width_q  <= cfg_data;
          REG_SRC_HEIGHT:  height_q <= cfg_data;
          REG_OUT_SIDE:    side_q   <= cfg_data;
          REG_CENTER_MODE: center_q <= cfg_data[0];
          REG_FILL_LEVEL:  fill_q   <= cfg_data[FILL_W-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready)
        pending_addrs.push_back(letterbox_map(pix_in.out_x, pix_in.out_y));
      if (pix_out.valid && pix_out.ready) begin
        if (pending_addrs.size() == 0) begin
          $error("address word with no pixel waiting");
          errors++;
        end else begin
          want = pending_addrs.pop_front();
          check_field("in_image",  want.in_image,  pix_out.in_image);
          check_field("src_col",   want.src_col,   pix_out.src_col);
          check_field("src_row",   want.src_row,   pix_out.src_row);
          check_field("src_index", want.src_index, pix_out.src_index);
          check_field("pad_value", want.pad_value, pix_out.pad_value);
        end
      end
      pending <= pending_addrs.size();
    end
  end

endmodule

/* sim/letterbox_resize_address_gen_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letterbox_resize_address_gen_test
// Drives output pixel coordinates through the letterbox address generator
// over a series of frame geometries, with random gaps on both channels; the
// checker instance predicts and compares every address word.
// ----------------------------------------------------------------------------

module letterbox_resize_address_gen_test;
  import lbr_pkg::*;

  localparam int MAX_DIM     = 4096;
  localparam int DIV_W       = $clog2(MAX_DIM + 1);
  localparam int LATENCY     = DIV_W + 5;   // pipeline depth, input to output
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 17;
  localparam int RAND_WORDS  = 40;          // random pixels per geometry

  // index past the last register; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef struct {
    logic [DIM_REG_W-1:0] width;
    logic [DIM_REG_W-1:0] height;
    logic [DIM_REG_W-1:0] side;
    logic                 center;
    logic [FILL_W-1:0]    fill;
  } frame_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  lbr_in_if  pix_in ();
  lbr_out_if pix_out ();

  letterbox_resize_address_gen #(.MAX_DIM(MAX_DIM)) uut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  letterbox_addr_checker #(.MAX_DIM(MAX_DIM)) addr_check (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stalls at the rate of the current phase, a fresh draw each cycle.
  initial begin
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pix_out.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One pixel word; optional idle cycles first, then hold until accepted.
  // Returns at the accepting edge so the next word can follow back to back.
  task automatic send_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.out_x <= x;
    pix_in.out_y <= y;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
  endtask

  // Sender goes quiet until every address word is back, plus pipeline slack.
  // The first edge lets the checker count the word accepted at this step.
  task automatic drain_words();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // a coordinate a few pixels around the frame middle, where centered
  // thin images live
  function automatic logic [COORD_W-1:0] near_mid(int side_px);
    int c;
    c = side_px / 2 - 3 + $urandom_range(6);
    if (c < 0) c = 0;
    if (c >= side_px) c = side_px - 1;
    return COORD_W'(c);
  endfunction

  initial begin
    frame_cfg_t       cfg;
    int               side_px;
    int unsigned      pick;
    logic [COORD_W-1:0] x, y;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SRC_WIDTH;
    cfg_data      <= '0;
    pix_in.valid  <= 1'b0;
    pix_in.out_x  <= '0;
    pix_in.out_y  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    cfg = '{DIM_RESET, DIM_RESET, DIM_RESET, 1'b0, '0};

    for (int p = 0; p < PHASES; p++) begin
      // geometry changes only with the pipeline empty
      if (p > 0) begin
        drain_words();
        case (p)
          1:  cfg = '{13'd640,  13'd480,  13'd640,  1'b1, 8'd114}; // classic letterbox
          2:  cfg = '{13'd1920, 13'd1080, 13'd640,  1'b1, 8'd255}; // downscale
          3:  cfg = '{13'd8191, 13'd8191, 13'd8191, 1'b0, 8'd0};   // all saturate
          4:  cfg = '{13'd1,    13'd4096, 13'd1,    1'b1, 8'd37};  // scaled width zero
          5:  cfg = '{13'd0,    13'd480,  13'd640,  1'b0, 8'd200}; // zero source width
          6:  cfg = '{13'd300,  13'd200,  13'd0,    1'b1, 8'd85};  // zero frame side
          7:  cfg = '{13'd1,    13'd1,    13'd1,    1'b0, 8'd170}; // one pixel
          8:  cfg = '{13'd4096, 13'd1,    13'd4096, 1'b1, 8'd255}; // one row tall
          9:  cfg = '{13'd3,    13'd5,    13'd4096, 1'b1, 8'd1};   // frame larger than src
          10: cfg = '{13'd4095, 13'd4094, 13'd4093, 1'b1, 8'd99};
          11: cfg = '{13'd7,    13'd13,   13'd5,    1'b1, 8'd66};  // frame smaller than src
          12: cfg = '{13'd4096, 13'd4096, 13'd1,    1'b0, 8'd240};
          default: begin
            cfg.width  = ($urandom_range(3) == 0) ? DIM_REG_W'($urandom) :
                                                    DIM_REG_W'($urandom_range(40, 1));
            cfg.height = ($urandom_range(3) == 0) ? DIM_REG_W'($urandom) :
                                                    DIM_REG_W'($urandom_range(40, 1));
            cfg.side   = DIM_REG_W'($urandom_range(48, 1));
            cfg.center = 1'($urandom_range(1));
            cfg.fill   = FILL_W'($urandom);
          end
        endcase
        write_reg(REG_SRC_WIDTH,   cfg.width);
        write_reg(REG_SRC_HEIGHT,  cfg.height);
        write_reg(REG_OUT_SIDE,    cfg.side);
        // upper data bits are junk for the narrow registers
        write_reg(REG_CENTER_MODE, CFG_DATA_W'({$urandom, cfg.center}));
        write_reg(REG_FILL_LEVEL,  CFG_DATA_W'({$urandom, cfg.fill}));
        if (p > 12)
          write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
      end

      // rotate through the idling modes
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct = 22; recv_stall_pct <= 22; end
      endcase

      // directed words: corners, frame edges and region boundaries
      case (p)
        0: begin
          send_word(12'd0, 12'd0);
          send_word(12'd639, 12'd639);
          send_word(12'd640, 12'd0);     // right of the frame
          send_word(12'd0, 12'd640);     // below the frame
          send_word(12'hFFF, 12'hFFF);
          send_word(12'hAAA, 12'h555);
          send_word(12'h555, 12'hAAA);
        end
        1: begin
          send_word(12'd0, 12'd79);      // top band, pad
          send_word(12'd0, 12'd80);      // first image row
          send_word(12'd639, 12'd559);   // last image row
          send_word(12'd639, 12'd560);   // bottom band, pad
          send_word(12'd320, 12'd240);
        end
        2: begin
          send_word(12'd0, 12'd139);
          send_word(12'd0, 12'd140);
          send_word(12'd639, 12'd499);
          send_word(12'd639, 12'd500);
        end
        3: begin
          send_word(12'hFFF, 12'hFFF);   // largest linear index
          send_word(12'd0, 12'd0);
        end
        4: send_word(12'd0, 12'd0);
        5: begin
          send_word(12'd0, 12'd0);
          send_word(12'd100, 12'd100);
        end
        6: send_word(12'd0, 12'd0);
        7: begin
          send_word(12'd0, 12'd0);
          send_word(12'd1, 12'd0);
        end
        default: ;
      endcase

      // random words: mostly inside the frame, some anywhere
      side_px = (cfg.side > MAX_DIM) ? MAX_DIM : cfg.side;
      for (int i = 0; i < RAND_WORDS; i++) begin
        pick = $urandom_range(99);
        if (side_px != 0 && pick < 50) begin
          x = COORD_W'($urandom_range(side_px - 1));
          y = COORD_W'($urandom_range(side_px - 1));
        end else if (side_px != 0 && pick < 75) begin
          x = ($urandom_range(1) != 0) ? near_mid(side_px) : COORD_W'($urandom_range(side_px - 1));
          y = near_mid(side_px);
        end else begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end
        send_word(x, y);
      end
    end

    drain_words();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/lbr_pkg.sv
rtl/lbr_if.sv
rtl/lbr_setup.sv
rtl/lbr_coord_div.sv
rtl/letterbox_resize_address_gen.sv
sim/letterbox_addr_checker.sv
sim/letterbox_resize_address_gen_test.sv
